### hdl/fbfl_pkg.sv
// shared types and constants for the fixed block free list allocator
// no dependencies; imported by fbfl_div and fixed_block_free_list_allocator
package fbfl_pkg;

    localparam int ADDR_W      = 14;
    localparam int STATUS_W    = 3;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    localparam int DEF_POOL_BLOCKS  = 64;
    localparam int DEF_BLOCK_BYTES  = 256;
    localparam int DEF_HEADER_BYTES = 16;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOC     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REINIT    = 3'd4;

    // divider result handed back to the sequencer
    typedef struct packed {
        logic              done;
        logic              rem_zero;
        logic [ADDR_W-1:0] quotient;
    } t_div_res;

endpackage

### hdl/fbfl_div.sv
// reciprocal multiply check of a payload offset against the fixed block size
// one shared multiplier used twice: quotient, then quotient times block size
// depends on fbfl_pkg
module fbfl_div #(
    parameter int BLOCK_BYTES = fbfl_pkg::DEF_BLOCK_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fbfl_pkg::ADDR_W-1:0]  i_dividend,
    output fbfl_pkg::t_div_res           o_res
);
    import fbfl_pkg::*;

    // floor(x / BLOCK_BYTES) is (x * RECIP) >> SHIFT for any ADDR_W bit x
    localparam int              SHIFT   = ADDR_W + $clog2(BLOCK_BYTES);
    localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + 64'(BLOCK_BYTES) - 64'd1)
                                          / 64'(BLOCK_BYTES);
    localparam int              MW      = ADDR_W + 1;
    localparam int              PW      = ADDR_W + MW;
    localparam logic [MW-1:0]   RECIP   = MW'(RECIP_L);
    // quotient times block size never exceeds the offset, so the low bits suffice
    localparam logic [MW-1:0]   BB_MOD  = MW'(BLOCK_BYTES % (1 << ADDR_W));

    typedef enum logic [2:0] {
        P_IDLE = 3'b001,
        P_QUO  = 3'b010,
        P_CHK  = 3'b100
    } t_phase;

    t_phase            r_phase;
    logic [ADDR_W-1:0] r_off;
    logic [ADDR_W-1:0] r_quo;
    logic              r_rem_zero;
    logic              r_done;

    logic [ADDR_W-1:0] mul_a;
    logic [MW-1:0]     mul_b;
    logic [PW-1:0]     mul_p;

    assign mul_a = (r_phase == P_QUO) ? r_off : r_quo;
    assign mul_b = (r_phase == P_QUO) ? RECIP : BB_MOD;
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_phase <= P_QUO;
                    end
                end
                P_QUO: begin
                    r_phase <= P_CHK;
                end
                P_CHK: begin
                    r_phase <= P_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_off <= i_dividend;
        end
        if (r_phase == P_QUO) begin
            r_quo <= ADDR_W'(mul_p >> SHIFT);
        end
        if (r_phase == P_CHK) begin
            r_rem_zero <= (mul_p[ADDR_W-1:0] == r_off);
        end
    end

    assign o_res.done     = r_done;
    assign o_res.rem_zero = r_rem_zero;
    assign o_res.quotient = r_quo;

endmodule

### hdl/fixed_block_free_list_allocator.sv
// fixed block free list allocator: a null free or exhausted pool is answered
// from idle, an allocate reads the head link first, a valid free makes 2 passes
// through the shared offset multiplier; the next request is taken once the
// result leaves; an invalid free rebuilds the link memory, then reports
// reset is synchronous active low and starts a clearing pass
// of the link memory; no request is taken until it ends
module fixed_block_free_list_allocator #(
    parameter int POOL_BLOCKS  = fbfl_pkg::DEF_POOL_BLOCKS,
    parameter int BLOCK_BYTES  = fbfl_pkg::DEF_BLOCK_BYTES,
    parameter int HEADER_BYTES = fbfl_pkg::DEF_HEADER_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request: [0] action, [14:1] free_addr, [15] zero
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [fbfl_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // result: [2:0] status, [16:3] alloc_addr, [23:17] zero
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [fbfl_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import fbfl_pkg::*;

    localparam int IW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam logic [IW-1:0]     LAST_IDX = IW'(POOL_BLOCKS - 1);
    localparam logic [ADDR_W-1:0] HDR      = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] NBLK     = ADDR_W'(POOL_BLOCKS);
    // block size modulo the address range, enough for a masked product
    localparam logic [ADDR_W-1:0] BB_MOD   = ADDR_W'(BLOCK_BYTES % (1 << ADDR_W));

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,   // link memory sweep after reset or corruption
        S_IDLE  = 4'b0010,   // waiting for a request
        S_ALLOC = 4'b0100,   // link of the head block being read
        S_DIV   = 4'b1000    // free address being checked by the divider
    } t_state;

    t_state            r_state, n_state;

    // free list state
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic              r_empty, n_empty;
    logic [IW-1:0]     r_clr_idx, n_clr_idx;
    logic              r_reinit, n_reinit;

    // link memory, registered read at the head index
    logic [IW-1:0]     r_mem [POOL_BLOCKS];
    logic [IW-1:0]     r_link_q;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [IW-1:0]     mem_wdata;

    // result register
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;

    // request fields
    logic              in_action;
    logic [ADDR_W-1:0] in_addr;
    logic              accept;

    // divider
    logic              div_start;
    logic [ADDR_W-1:0] div_dividend;
    t_div_res          div_res;
    logic              free_ok;
    logic [ADDR_W-1:0] alloc_addr;

    assign in_action = i_s_tdata[0];
    assign in_addr   = i_s_tdata[ADDR_W:1];

    // the result register is free by the time any request finishes
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    assign div_dividend = in_addr - HDR;
    assign div_start    = accept && (in_action == ACT_FREE) &&
                          (in_addr != '0) && (in_addr >= HDR);

    fbfl_div #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_res      (div_res)
    );

    // payload start of the head block, masked to the address width
    assign alloc_addr = (ADDR_W'(r_head) * BB_MOD) + HDR;

    assign free_ok = div_res.rem_zero && (div_res.quotient < NBLK);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_empty      = r_empty;
        n_clr_idx    = r_clr_idx;
        n_reinit     = r_reinit;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        mem_we       = 1'b0;
        mem_waddr    = r_clr_idx;
        mem_wdata    = (r_clr_idx == LAST_IDX) ? '0 : (r_clr_idx + 1'b1);

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_IDX) begin
                    n_clr_idx = '0;
                    n_head    = '0;
                    n_tail    = LAST_IDX;
                    n_empty   = 1'b0;
                    n_reinit  = 1'b0;
                    n_state   = S_IDLE;
                    // corruption repair reports once the list is whole again
                    if (r_reinit) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_REINIT;
                        n_out_addr   = '0;
                    end
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (in_action == ACT_ALLOC) begin
                        if (r_empty) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_EXHAUSTED;
                            n_out_addr   = '0;
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end else if (in_addr == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_NULL;
                        n_out_addr   = '0;
                    end else if (in_addr < HDR) begin
                        // below the first payload start: rebuild the list
                        n_reinit  = 1'b1;
                        n_clr_idx = '0;
                        n_state   = S_CLEAR;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_ALLOC: begin
                // head link arrives from memory this cycle
                if (r_head == r_tail) begin
                    n_empty = 1'b1;
                end else begin
                    n_head = r_link_q;
                end
                n_out_valid  = 1'b1;
                n_out_status = ST_ALLOC;
                n_out_addr   = alloc_addr;
                n_state      = S_IDLE;
            end
            S_DIV: begin
                if (div_res.done) begin
                    if (!free_ok) begin
                        n_reinit  = 1'b1;
                        n_clr_idx = '0;
                        n_state   = S_CLEAR;
                    end else begin
                        // append at the tail, or start a fresh list
                        if (r_empty) begin
                            n_head  = div_res.quotient[IW-1:0];
                            n_empty = 1'b0;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_tail;
                            mem_wdata = div_res.quotient[IW-1:0];
                        end
                        n_tail       = div_res.quotient[IW-1:0];
                        n_out_valid  = 1'b1;
                        n_out_status = ST_FREED;
                        n_out_addr   = '0;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_head      <= '0;
            r_tail      <= LAST_IDX;
            r_empty     <= 1'b0;
            r_clr_idx   <= '0;
            r_reinit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_clr_idx   <= n_clr_idx;
            r_reinit    <= n_reinit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_link_q <= r_mem[r_head];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - ADDR_W - STATUS_W){1'b0}}, r_out_addr, r_out_status};

endmodule

### tb/fixed_block_free_list_allocator_tb.sv
// self-checking testbench for fixed_block_free_list_allocator: a directed table,
// then random request bursts checked against a behavioral free list predictor
// depends on fbfl_pkg and the allocator rtl only
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_tb;

    import fbfl_pkg::*;

    localparam int NB     = DEF_POOL_BLOCKS;
    localparam int BB     = DEF_BLOCK_BYTES;
    localparam int HB     = DEF_HEADER_BYTES;
    localparam int IDX_W  = $clog2(NB);

    // longest correct silence is an invalid free (link rebuild) behind a long
    // stall; reaching this limit without a handshake can only mean a hang
    localparam int WATCHDOG_LIMIT = 4000;
    // quiet time after the last result, covers a rebuild still in flight
    localparam int SETTLE_CYCLES  = 2 * NB + 32;
    localparam int PHASE_REQUESTS = 460;
    localparam int N_DIRECTED     = 22;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } result_t;

    // one row of the directed table; checked rows carry a hand-typed result
    typedef struct packed {
        logic                act;
        logic [ADDR_W-1:0]   addr;
        bit                  checked;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   alloc_addr;
    } req_row_t;

    localparam req_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // first allocations after reset come from block 0 then block 1
        '{ACT_ALLOC, 14'd0,     1'b1, ST_ALLOC,  14'd16},
        '{ACT_ALLOC, 14'h3FFF,  1'b1, ST_ALLOC,  14'd272},   // address ignored
        '{ACT_FREE,  14'd0,     1'b1, ST_NULL,   14'd0},     // null pointer
        '{ACT_FREE,  14'd16,    1'b1, ST_FREED,  14'd0},     // block 0 back
        '{ACT_FREE,  14'd16144, 1'b1, ST_FREED,  14'd0},     // last block, double free
        '{ACT_ALLOC, 14'd0,     1'b0, ST_ALLOC,  14'd0},
        // invalid addresses: below header, misaligned, all ones
        '{ACT_FREE,  14'd1,     1'b1, ST_REINIT, 14'd0},
        '{ACT_FREE,  14'd15,    1'b1, ST_REINIT, 14'd0},
        '{ACT_FREE,  14'd17,    1'b1, ST_REINIT, 14'd0},
        '{ACT_FREE,  14'h3FFF,  1'b1, ST_REINIT, 14'd0},
        '{ACT_FREE,  14'd16160, 1'b1, ST_REINIT, 14'd0},
        // list restored in order
        '{ACT_ALLOC, 14'd0,     1'b1, ST_ALLOC,  14'd16},
        '{ACT_ALLOC, 14'd0,     1'b1, ST_ALLOC,  14'd272},
        '{ACT_FREE,  14'd16,    1'b1, ST_FREED,  14'd0},
        '{ACT_FREE,  14'd272,   1'b1, ST_FREED,  14'd0},
        '{ACT_FREE,  14'd16,    1'b0, ST_FREED,  14'd0},     // double free
        '{ACT_ALLOC, 14'd0,     1'b0, ST_ALLOC,  14'd0},
        '{ACT_FREE,  14'd8208,  1'b0, ST_FREED,  14'd0},     // block 32
        '{ACT_FREE,  14'd10768, 1'b0, ST_FREED,  14'd0},     // block 42
        '{ACT_ALLOC, 14'd0,     1'b0, ST_ALLOC,  14'd0},
        '{ACT_FREE,  14'h2000,  1'b1, ST_REINIT, 14'd0},
        '{ACT_ALLOC, 14'd0,     1'b1, ST_ALLOC,  14'd16}
    };

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // request: [0] action, [14:1] free_addr, [15] zero
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // result: [2:0] status, [16:3] alloc_addr, [23:17] zero
    logic [OUT_DATA_W-1:0] o_m_tdata;

    fixed_block_free_list_allocator #(
        .POOL_BLOCKS (NB),
        .BLOCK_BYTES (BB),
        .HEADER_BYTES(HB)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the free list
    logic [IDX_W-1:0] link_mem [NB];
    logic [IDX_W-1:0] head_blk;
    logic [IDX_W-1:0] tail_blk;
    logic             pool_empty;
    // blocks handed out and not yet returned, steers well-formed frees
    bit               held [NB];

    result_t pending_results [$];
    int      mismatches = 0;
    int      idle_pct   = 0;
    int      stall_pct  = 0;
    int      quiet_cycles = 0;

    function automatic void rebuild_free_list();
        for (int i = 0; i < NB; i++) begin
            link_mem[i] = IDX_W'((i + 1) % NB);
            held[i]     = 1'b0;
        end
        head_blk   = '0;
        tail_blk   = IDX_W'(NB - 1);
        pool_empty = 1'b0;
    endfunction

    // apply one accepted request to the free list, return its result
    function automatic result_t apply_request(logic act, logic [ADDR_W-1:0] addr);
        result_t r;
        int      off;
        int      blk;
        r.status = ST_ALLOC;
        r.addr   = '0;
        if (act == ACT_ALLOC) begin
            if (pool_empty) begin
                r.status = ST_EXHAUSTED;
            end else begin
                blk = int'(head_blk);
                // taking the only listed block empties the list
                if (head_blk == tail_blk) begin
                    pool_empty = 1'b1;
                end else begin
                    head_blk = link_mem[head_blk];
                end
                r.addr    = ADDR_W'(blk * BB + HB);
                held[blk] = 1'b1;
            end
        end else if (addr == '0) begin
            r.status = ST_NULL;
        end else begin
            off = int'(addr) - HB;
            if (off >= 0 && off % BB == 0 && off / BB < NB) begin
                blk = off / BB;
                if (pool_empty) begin
                    head_blk   = IDX_W'(blk);
                    pool_empty = 1'b0;
                end else begin
                    link_mem[tail_blk] = IDX_W'(blk);
                end
                tail_blk  = IDX_W'(blk);
                held[blk] = 1'b0;
                r.status  = ST_FREED;
            end else begin
                rebuild_free_list();
                r.status = ST_REINIT;
            end
        end
        return r;
    endfunction

    // payload address of a block currently handed out, any block if none is
    function automatic logic [ADDR_W-1:0] held_block_addr();
        int cand [$];
        int pick;
        for (int i = 0; i < NB; i++) begin
            if (held[i]) cand.push_back(i);
        end
        if (cand.size() == 0) begin
            pick = $urandom_range(NB - 1);
        end else begin
            pick = cand[$urandom_range(cand.size() - 1)];
        end
        return ADDR_W'(pick * BB + HB);
    endfunction

    // hold one request until accepted, then queue its result and maybe idle
    task automatic send_request(logic act, logic [ADDR_W-1:0] addr,
                                bit checked, result_t typed);
        result_t r;
        int      gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, addr, act};
        do @(posedge i_clk); while (!o_s_tready);
        r = apply_request(act, addr);
        pending_results.push_back(checked ? typed : r);
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_alloc();
        send_request(ACT_ALLOC, ADDR_W'($urandom), 1'b0, '0);
    endtask

    task automatic send_free(logic [ADDR_W-1:0] addr);
        send_request(ACT_FREE, addr, 1'b0, '0);
    endtask

    // result checking, receiver stalls and the watchdog
    always @(posedge i_clk) begin : result_check
        result_t want;
        i_m_tready <= ($urandom_range(99) >= stall_pct);
        if (o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: tdata %h", o_m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[STATUS_W-1:0] !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, o_m_tdata[STATUS_W-1:0]);
                    mismatches++;
                end
                if (o_m_tdata[STATUS_W +: ADDR_W] !== want.addr) begin
                    $error("alloc_addr mismatch: expected %0d, got %0d",
                           want.addr, o_m_tdata[STATUS_W +: ADDR_W]);
                    mismatches++;
                end
                if (o_m_tdata[OUT_DATA_W-1:STATUS_W+ADDR_W] !== '0) begin
                    $error("pad mismatch: expected 0, got %h",
                           o_m_tdata[OUT_DATA_W-1:STATUS_W+ADDR_W]);
                    mismatches++;
                end
            end
        end
        // watchdog: any handshake on either side counts as progress
        if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int sent;
        int n;
        int kind;
        int sel;
        int idle_tab  [4] = '{0, 82, 0, 12};
        int stall_tab [4] = '{0, 0, 82, 12};
        rebuild_free_list();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, no idling on either side
        for (int k = 0; k < N_DIRECTED; k++) begin
            send_request(DIRECTED_ROWS[k].act, DIRECTED_ROWS[k].addr,
                         DIRECTED_ROWS[k].checked,
                         '{DIRECTED_ROWS[k].status, DIRECTED_ROWS[k].alloc_addr});
        end

        // random bursts; drains run the pool dry (last block taken, exhausted),
        // refills return handed-out blocks (free into an empty list), noise
        // covers null, misaligned, out-of-pool and double frees
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            sent = 0;
            while (sent < PHASE_REQUESTS) begin
                kind = $urandom_range(99);
                if (kind < 30) begin
                    n = $urandom_range(80, 8);
                    repeat (n) send_alloc();
                end else if (kind < 60) begin
                    n = $urandom_range(64, 4);
                    repeat (n) send_free(held_block_addr());
                end else if (kind < 90) begin
                    n = $urandom_range(60, 10);
                    repeat (n) begin
                        if ($urandom_range(1) == 0) send_alloc();
                        else send_free(held_block_addr());
                    end
                end else begin
                    n = $urandom_range(4, 1);
                    repeat (n) begin
                        sel = $urandom_range(4);
                        case (sel)
                            0: send_free('0);
                            1: send_free(ADDR_W'($urandom_range(16383)));
                            2: send_free(held_block_addr()
                                         + ADDR_W'($urandom_range(BB - 1, 1)));
                            3: send_free(ADDR_W'($urandom_range(NB - 1) * BB + HB));
                            default: send_free(ADDR_W'($urandom_range(HB - 1, 1)));
                        endcase
                    end
                end
                sent += n;
            end
        end
        i_s_tvalid <= 1'b0;

        // drain, then give a late or spurious result time to show up
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/fbfl_pkg.sv
hdl/fbfl_div.sv
hdl/fixed_block_free_list_allocator.sv
tb/fixed_block_free_list_allocator_tb.sv
